// ===== rtl/core/id3p_pkg.sv =====
// Shared types and constants for the ID3v2 tag frame parser.
`timescale 1ns / 1ps

package id3p_pkg;

   localparam int CNT_W    = 28;
   localparam int SIZE_W   = 28;
   localparam int REGION_W = 29;

   localparam logic [CNT_W-1:0] TAG_HDR_LAST   = 28'd9;
   localparam logic [CNT_W-1:0] FRAME_HDR_LAST = 28'd9;
   localparam logic [CNT_W-1:0] EXT_SIZE_LAST  = 28'd3;
   localparam logic [CNT_W-1:0] SIG_LEN        = 28'd3;
   localparam logic [CNT_W-1:0] FLAGS_BYTE     = 28'd5;
   localparam logic [CNT_W-1:0] SIZE_FIRST     = 28'd6;
   localparam logic [CNT_W-1:0] ID_END         = 28'd4;
   localparam logic [CNT_W-1:0] FSIZE_END      = 28'd8;
   localparam logic [SIZE_W-1:0] EXT_SIZE_LEN  = 28'd4;
   localparam logic [REGION_W:0] FRAME_HDR_LEN = 30'd10;
   localparam logic [REGION_W-1:0] REGION_MAX  = 29'h1FFF_FFFF;

   typedef enum logic [2:0] {
      PH_TAG_HDR    = 3'd0,
      PH_EXT_SIZE   = 3'd1,
      PH_EXT_SKIP   = 3'd2,
      PH_FRAME_HDR  = 3'd3,
      PH_FRAME_DATA = 3'd4,
      PH_IDLE       = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_FRAME_HDR = 2'd0,
      KIND_DATA      = 2'd1,
      KIND_NOT_ID3   = 2'd2
   } kind_type;

   typedef struct packed {
      phase_type             phase;
      logic [CNT_W-1:0]      byte_counter;
      logic [SIZE_W-1:0]     tag_size;
      logic                  has_ext_header;
      logic [SIZE_W-1:0]     ext_size;
      logic [REGION_W-1:0]   region_used;
      logic [31:0]           cur_frame_id;
      logic [SIZE_W-1:0]     cur_frame_size;
      logic [15:0]           cur_frame_flags;
   } parser_state_type;

   localparam parser_state_type STATE_RESET = '{
      phase:           PH_TAG_HDR,
      byte_counter:    '0,
      tag_size:        '0,
      has_ext_header:  1'b0,
      ext_size:        '0,
      region_used:     '0,
      cur_frame_id:    '0,
      cur_frame_size:  '0,
      cur_frame_flags: '0
   };

   typedef struct packed {
      kind_type          kind;
      logic [31:0]       frame_id;
      logic [SIZE_W-1:0] frame_size;
      logic [15:0]       frame_flags;
      logic [7:0]        data_byte;
      logic              last;
   } result_type;

   // Signature byte expected at header positions 0..2 ("ID3").
   function automatic logic [7:0] sig_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h49;
         2'd1:    val = 8'h44;
         2'd2:    val = 8'h33;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/core/id3p_step.sv =====
// Next-state and result logic for one stream byte of the ID3v2 parser.
`timescale 1ns / 1ps

module id3p_step (
   input  id3p_pkg::parser_state_type state_i,
   input  logic [7:0]                 stream_byte_i,
   input  logic                       start_of_file_i,
   output id3p_pkg::parser_state_type state_o,
   output logic                       res_valid_o,
   output id3p_pkg::result_type       res_o
);

   // True while the tag region, tag size less extended header size, still has room.
   function automatic logic more_frames(input id3p_pkg::parser_state_type s);
      logic [id3p_pkg::SIZE_W-1:0] len;
      len = (s.tag_size > s.ext_size) ? (s.tag_size - s.ext_size) : '0;
      return s.region_used < {1'b0, len};
   endfunction

   id3p_pkg::parser_state_type st;
   id3p_pkg::parser_state_type ns;
   logic [id3p_pkg::CNT_W-1:0]    cnt;
   logic [id3p_pkg::CNT_W:0]      cnt_next_wide;
   logic [id3p_pkg::REGION_W:0]   sum;

   always_comb begin
      st            = start_of_file_i ? id3p_pkg::STATE_RESET : state_i;
      ns            = st;
      cnt           = st.byte_counter;
      cnt_next_wide = {1'b0, cnt} + 29'd1;
      sum           = '0;
      res_valid_o   = 1'b0;
      res_o         = '0;
      case (st.phase)
         id3p_pkg::PH_TAG_HDR: begin
            if ((cnt < id3p_pkg::SIG_LEN) &&
                (stream_byte_i != id3p_pkg::sig_byte(cnt[1:0]))) begin
               ns.phase           = id3p_pkg::PH_IDLE;
               ns.cur_frame_id    = '0;
               ns.cur_frame_size  = '0;
               ns.cur_frame_flags = '0;
               res_valid_o        = 1'b1;
               res_o.kind         = id3p_pkg::KIND_NOT_ID3;
            end else begin
               if (cnt == id3p_pkg::FLAGS_BYTE) begin
                  ns.has_ext_header = stream_byte_i[6];
               end
               if (cnt >= id3p_pkg::SIZE_FIRST) begin
                  ns.tag_size = {st.tag_size[20:0], stream_byte_i[6:0]};
               end
               if (cnt >= id3p_pkg::TAG_HDR_LAST) begin
                  ns.byte_counter = '0;
                  if (ns.has_ext_header) begin
                     ns.phase = id3p_pkg::PH_EXT_SIZE;
                  end else begin
                     ns.phase = more_frames(ns) ? id3p_pkg::PH_FRAME_HDR
                                                : id3p_pkg::PH_IDLE;
                  end
               end else begin
                  ns.byte_counter = cnt_next_wide[id3p_pkg::CNT_W-1:0];
               end
            end
         end
         id3p_pkg::PH_EXT_SIZE: begin
            ns.ext_size = {st.ext_size[20:0], stream_byte_i[6:0]};
            if (cnt >= id3p_pkg::EXT_SIZE_LAST) begin
               ns.byte_counter = '0;
               if (ns.ext_size > id3p_pkg::EXT_SIZE_LEN) begin
                  ns.phase = id3p_pkg::PH_EXT_SKIP;
               end else begin
                  ns.phase = more_frames(ns) ? id3p_pkg::PH_FRAME_HDR
                                             : id3p_pkg::PH_IDLE;
               end
            end else begin
               ns.byte_counter = cnt_next_wide[id3p_pkg::CNT_W-1:0];
            end
         end
         id3p_pkg::PH_EXT_SKIP: begin
            if (cnt_next_wide >= {1'b0, st.ext_size - id3p_pkg::EXT_SIZE_LEN}) begin
               ns.byte_counter = '0;
               ns.phase = more_frames(ns) ? id3p_pkg::PH_FRAME_HDR : id3p_pkg::PH_IDLE;
            end else begin
               ns.byte_counter = cnt_next_wide[id3p_pkg::CNT_W-1:0];
            end
         end
         id3p_pkg::PH_FRAME_HDR: begin
            if (cnt == '0) begin
               ns.cur_frame_id    = {24'd0, stream_byte_i};
               ns.cur_frame_size  = '0;
               ns.cur_frame_flags = '0;
            end else if (cnt < id3p_pkg::ID_END) begin
               ns.cur_frame_id = {st.cur_frame_id[23:0], stream_byte_i};
            end else if (cnt < id3p_pkg::FSIZE_END) begin
               ns.cur_frame_size = {st.cur_frame_size[20:0], stream_byte_i[6:0]};
            end else begin
               ns.cur_frame_flags = {st.cur_frame_flags[7:0], stream_byte_i};
            end
            if (cnt >= id3p_pkg::FRAME_HDR_LAST) begin
               // Account header plus payload, saturating at the region limit.
               sum = {1'b0, st.region_used} + id3p_pkg::FRAME_HDR_LEN +
                     {2'd0, ns.cur_frame_size};
               ns.region_used = sum[id3p_pkg::REGION_W] ? id3p_pkg::REGION_MAX
                                                        : sum[id3p_pkg::REGION_W-1:0];
               res_valid_o       = 1'b1;
               res_o.kind        = id3p_pkg::KIND_FRAME_HDR;
               res_o.frame_id    = ns.cur_frame_id;
               res_o.frame_size  = ns.cur_frame_size;
               res_o.frame_flags = ns.cur_frame_flags;
               ns.byte_counter   = '0;
               if (ns.cur_frame_size == '0) begin
                  ns.phase = more_frames(ns) ? id3p_pkg::PH_FRAME_HDR
                                             : id3p_pkg::PH_IDLE;
               end else begin
                  ns.phase = id3p_pkg::PH_FRAME_DATA;
               end
            end else begin
               ns.byte_counter = cnt_next_wide[id3p_pkg::CNT_W-1:0];
            end
         end
         id3p_pkg::PH_FRAME_DATA: begin
            res_valid_o       = 1'b1;
            res_o.kind        = id3p_pkg::KIND_DATA;
            res_o.frame_id    = st.cur_frame_id;
            res_o.frame_size  = st.cur_frame_size;
            res_o.frame_flags = st.cur_frame_flags;
            res_o.data_byte   = stream_byte_i;
            res_o.last        = cnt_next_wide >= {1'b0, st.cur_frame_size};
            if (res_o.last) begin
               ns.byte_counter = '0;
               ns.phase = more_frames(ns) ? id3p_pkg::PH_FRAME_HDR : id3p_pkg::PH_IDLE;
            end else begin
               ns.byte_counter = cnt_next_wide[id3p_pkg::CNT_W-1:0];
            end
         end
         default: begin
            ns = st;
         end
      endcase
      state_o = ns;
   end

endmodule

// ===== rtl/core/id3v2_tag_frame_parser_unit.sv =====
// Top level of the ID3v2 tag frame parser: input register, parser state, result register.
`timescale 1ns / 1ps

//  Channel | Ports  | Payload
//  --------+--------+---------------------------------------------------------
//  input   | req_*  | tdata: stream_byte; tuser: start_of_file
//  result  | rsp_*  | tdata: frame_id, frame_size, frame_flags, data_byte;
//          |        | tuser: result_kind; tlast: last_of_frame
//
//  One byte per cycle sustained while rsp_tready does not stall. A transferred
//  byte is held in the input register; the parser step then updates the state
//  and loads any result into the result register, which offers it on rsp_*.
//  Synchronous active-high reset returns the parser to the tag header phase.
//  A stall on rsp_tready holds the result register and the byte waiting
//  behind it; req_tready drops only while both are held.

module id3v2_tag_frame_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   input  logic [0:0]  req_tuser,   // [0] start_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // [31:0] frame_id, [59:32] frame_size,
                                    // [75:60] frame_flags, [83:76] data_byte, [87:84] zero
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast    // last_of_frame
);

   // Input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_sof_ff;

   // Parser state
   id3p_pkg::parser_state_type state_ff;
   id3p_pkg::parser_state_type state_in;

   // Result register
   logic                 out_valid_ff;
   logic                 out_valid_in;
   id3p_pkg::result_type out_res_ff;

   logic                 step_valid;
   id3p_pkg::result_type step_res;
   logic                 advance;
   logic                 req_fire;

   // Retire the held byte when the result register can take its outcome.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   id3p_step u_step (
      .state_i         (state_ff),
      .stream_byte_i   (in_byte_ff),
      .start_of_file_i (in_sof_ff),
      .state_o         (state_in),
      .res_valid_o     (step_valid),
      .res_o           (step_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = step_valid;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= id3p_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload: load the byte on transfer, the result when the step produces one.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_sof_ff  <= req_tuser[0];
      end
      if (advance && step_valid) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_res_ff.data_byte, out_res_ff.frame_flags,
                        out_res_ff.frame_size, out_res_ff.frame_id};
   assign rsp_tuser  = out_res_ff.kind;
   assign rsp_tlast  = out_res_ff.last;

endmodule

// ===== rtl/core/id3p_checker.sv =====
// Port-level checks for the ID3v2 tag frame parser, bound to the top level.
`timescale 1ns / 1ps

module id3p_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == id3p_pkg::KIND_FRAME_HDR) ||
                     (rsp_tuser == id3p_pkg::KIND_DATA) ||
                     (rsp_tuser == id3p_pkg::KIND_NOT_ID3))
      else $error("illegal result kind");

   a_not_id3_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == id3p_pkg::KIND_NOT_ID3) |->
         (rsp_tdata == '0) && !rsp_tlast)
      else $error("signature failure carries payload");

   a_last_on_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tuser == id3p_pkg::KIND_DATA))
      else $error("frame end marked outside payload");

   a_hdr_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == id3p_pkg::KIND_FRAME_HDR) |->
         (rsp_tdata[87:76] == '0))
      else $error("frame header carries a data byte");

endmodule

bind id3v2_tag_frame_parser_unit id3p_checker u_id3p_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== bench/id3v2_tag_frame_parser_unit_tb.sv =====
// Self-checking testbench for the ID3v2 tag frame parser: streamed files, shadow parser, scoreboard.
`timescale 1ns / 1ps

module id3v2_tag_frame_parser_unit_tb;

   // Stop the run long after the slowest legal schedule could have finished.
   localparam int CYCLE_LIMIT  = 600000;
   // Random stimulus volume in bytes, the long-hold file included.
   localparam int RANDOM_BYTES = 1400;
   // Length of the deliberate receiver hold-off, in cycles.
   localparam int LONG_HOLD    = 250;

   localparam logic [7:0] ID3_SIG [0:2] = '{8'h49, 8'h44, 8'h33};

   typedef struct packed {
      logic [7:0] value;
      logic       sof;
   } stream_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] stream_byte
   logic [0:0]  req_tuser = '0;   // [0] start_of_file
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;        // [31:0] frame_id, [59:32] frame_size, [75:60] frame_flags,
                                  // [83:76] data_byte, [87:84] zero
   logic [1:0]  rsp_tuser;        // [1:0] result_kind
   logic        rsp_tlast;        // last_of_frame

   id3v2_tag_frame_parser_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Stimulus and scoreboard storage
   // ---------------------------------------------------------------------
   stream_item_type      pending_bytes[$];     // bytes waiting to be offered, front is on the bus
   logic [7:0]           file_buf[$];          // file under construction
   id3p_pkg::result_type expected_results[$];  // predicted results, oldest first

   int  bytes_taken = 0;
   int  bytes_taken_seen = 0;
   int  results_taken = 0;
   int  results_taken_seen = 0;
   int  hold_requests = 0;
   int  hold_served = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  stimulus_bytes = 0;
   bit  sender_busy = 1'b1;
   bit  receiver_busy = 1'b1;

   // ---------------------------------------------------------------------
   // Shadow parser state
   // ---------------------------------------------------------------------
   id3p_pkg::phase_type            parse_phase;
   logic [id3p_pkg::CNT_W-1:0]     byte_pos;
   logic [id3p_pkg::SIZE_W-1:0]    tag_len;
   logic                           ext_present;
   logic [id3p_pkg::SIZE_W-1:0]    ext_len;
   logic [id3p_pkg::REGION_W-1:0]  region_used;
   logic [31:0]                    cur_id;
   logic [id3p_pkg::SIZE_W-1:0]    cur_len;
   logic [15:0]                    cur_flags;

   task automatic clear_parser();
      parse_phase = id3p_pkg::PH_TAG_HDR;
      byte_pos    = '0;
      tag_len     = '0;
      ext_present = 1'b0;
      ext_len     = '0;
      region_used = '0;
      cur_id      = '0;
      cur_len     = '0;
      cur_flags   = '0;
   endtask

   // Open the next frame while the frame region still has room, otherwise go quiet.
   task automatic frame_or_idle();
      logic [id3p_pkg::SIZE_W-1:0] region_len;
      region_len = (tag_len > ext_len) ? tag_len - ext_len : '0;
      byte_pos = '0;
      parse_phase = (region_used < {1'b0, region_len}) ? id3p_pkg::PH_FRAME_HDR
                                                       : id3p_pkg::PH_IDLE;
   endtask

   task automatic emit(input id3p_pkg::kind_type kind, input logic [7:0] data,
                       input logic last);
      id3p_pkg::result_type r;
      r.kind        = kind;
      r.frame_id    = cur_id;
      r.frame_size  = cur_len;
      r.frame_flags = cur_flags;
      r.data_byte   = data;
      r.last        = last;
      expected_results.push_back(r);
   endtask

   // Advance the shadow parser by one byte and queue any result it yields.
   task automatic parse_byte(input logic [7:0] b, input logic sof);
      logic [id3p_pkg::CNT_W-1:0]  pos;
      logic [id3p_pkg::REGION_W:0] sum;
      logic                        last;
      if (sof)
         clear_parser();
      pos = byte_pos;
      case (parse_phase)
         id3p_pkg::PH_TAG_HDR: begin
            if (pos < id3p_pkg::SIG_LEN && b != ID3_SIG[pos[1:0]]) begin
               // Bad signature: report once, then drop everything until the next file.
               parse_phase = id3p_pkg::PH_IDLE;
               cur_id      = '0;
               cur_len     = '0;
               cur_flags   = '0;
               emit(id3p_pkg::KIND_NOT_ID3, 8'h00, 1'b0);
            end else begin
               if (pos == id3p_pkg::FLAGS_BYTE)
                  ext_present = b[6];
               if (pos >= id3p_pkg::SIZE_FIRST)
                  tag_len = {tag_len[id3p_pkg::SIZE_W-8:0], b[6:0]};
               if (pos >= id3p_pkg::TAG_HDR_LAST) begin
                  byte_pos = '0;
                  if (ext_present)
                     parse_phase = id3p_pkg::PH_EXT_SIZE;
                  else
                     frame_or_idle();
               end else begin
                  byte_pos = pos + 28'd1;
               end
            end
         end
         id3p_pkg::PH_EXT_SIZE: begin
            ext_len = {ext_len[id3p_pkg::SIZE_W-8:0], b[6:0]};
            if (pos >= id3p_pkg::EXT_SIZE_LAST) begin
               byte_pos = '0;
               // A short extended header skips nothing.
               if (ext_len > id3p_pkg::EXT_SIZE_LEN)
                  parse_phase = id3p_pkg::PH_EXT_SKIP;
               else
                  frame_or_idle();
            end else begin
               byte_pos = pos + 28'd1;
            end
         end
         id3p_pkg::PH_EXT_SKIP: begin
            if (pos + 28'd1 >= ext_len - id3p_pkg::EXT_SIZE_LEN)
               frame_or_idle();
            else
               byte_pos = pos + 28'd1;
         end
         id3p_pkg::PH_FRAME_HDR: begin
            if (pos == '0) begin
               cur_id    = {24'd0, b};
               cur_len   = '0;
               cur_flags = '0;
            end else if (pos < id3p_pkg::ID_END) begin
               cur_id = {cur_id[23:0], b};
            end else if (pos < id3p_pkg::FSIZE_END) begin
               cur_len = {cur_len[id3p_pkg::SIZE_W-8:0], b[6:0]};
            end else begin
               cur_flags = {cur_flags[7:0], b};
            end
            if (pos >= id3p_pkg::FRAME_HDR_LAST) begin
               // Account the whole frame against the region, clamped at the counter limit.
               sum = {1'b0, region_used} + id3p_pkg::FRAME_HDR_LEN + {2'b00, cur_len};
               region_used = (sum > {1'b0, id3p_pkg::REGION_MAX}) ? id3p_pkg::REGION_MAX
                                                                  : sum[id3p_pkg::REGION_W-1:0];
               emit(id3p_pkg::KIND_FRAME_HDR, 8'h00, 1'b0);
               if (cur_len == '0) begin
                  frame_or_idle();
               end else begin
                  byte_pos = '0;
                  parse_phase = id3p_pkg::PH_FRAME_DATA;
               end
            end else begin
               byte_pos = pos + 28'd1;
            end
         end
         id3p_pkg::PH_FRAME_DATA: begin
            last = (pos + 28'd1 >= cur_len);
            emit(id3p_pkg::KIND_DATA, b, last);
            if (last)
               frame_or_idle();
            else
               byte_pos = pos + 28'd1;
         end
         default: begin
            // Past the tag: ignore until the next start of file.
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // File builders
   // ---------------------------------------------------------------------
   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   // Mostly printable ids, sometimes arbitrary bytes.
   function automatic logic [31:0] random_id();
      logic [31:0] id;
      id = '0;
      for (int k = 0; k < 4; k++)
         id = {id[23:0], ($urandom_range(0, 4) == 0) ? rand_byte()
                                                     : 8'(65 + $urandom_range(0, 25))};
      return id;
   endfunction

   task automatic put(input logic [7:0] v);
      file_buf.push_back(v);
   endtask

   // Syncsafe field, most significant group first; the ignored top bit is randomised.
   task automatic put_syncsafe(input logic [27:0] v);
      for (int k = 3; k >= 0; k--)
         put({1'($urandom_range(0, 1)), v[7*k +: 7]});
   endtask

   task automatic put_tag_header(input logic [7:0] flags, input logic [27:0] size);
      for (int k = 0; k < 3; k++)
         put(ID3_SIG[k]);
      put(rand_byte());
      put(rand_byte());
      put(flags);
      put_syncsafe(size);
   endtask

   task automatic put_frame(input logic [31:0] id, input logic [27:0] size,
                            input logic [15:0] flags, input int payload);
      put(id[31:24]);
      put(id[23:16]);
      put(id[15:8]);
      put(id[7:0]);
      put_syncsafe(size);
      put(flags[15:8]);
      put(flags[7:0]);
      repeat (payload) put(rand_byte());
   endtask

   // Move the first keep bytes of the built file to the send queue, flagging the first.
   task automatic send_file(input logic sof_first, input int keep);
      stream_item_type item;
      for (int k = 0; k < keep; k++) begin
         item.value = file_buf[k];
         item.sof   = (k == 0) ? sof_first : 1'b0;
         pending_bytes.push_back(item);
      end
      stimulus_bytes += keep;
      file_buf.delete();
   endtask

   task automatic put_random_file();
      int          style;
      int          bad_at;
      int          ext_bytes;
      int          body;
      int          pad;
      int          keep;
      int          sizes[$];
      logic        has_ext;
      logic [7:0]  flags;
      logic [7:0]  wrong;
      logic [27:0] region;
      style = int'($urandom_range(0, 15));
      if (style == 0) begin
         // Broken signature at a random position, then junk.
         bad_at = int'($urandom_range(0, 2));
         for (int k = 0; k < bad_at; k++)
            put(ID3_SIG[k]);
         wrong = rand_byte();
         if (wrong == ID3_SIG[bad_at])
            wrong = ~wrong;
         put(wrong);
         repeat ($urandom_range(0, 6)) put(rand_byte());
      end else if (style == 1) begin
         repeat ($urandom_range(1, 12)) put(rand_byte());
      end else begin
         has_ext   = ($urandom_range(0, 3) == 0);
         ext_bytes = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 3))
                                                 : int'($urandom_range(4, 14));
         body = 0;
         repeat ($urandom_range(0, 4)) begin
            sizes.push_back(($urandom_range(0, 9) == 0) ? int'($urandom_range(17, 60))
                                                        : int'($urandom_range(0, 16)));
            body += 10 + sizes[$];
         end
         pad = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 24)) : 0;
         body += pad;
         region = 28'(body + (has_ext ? ext_bytes : 0));
         // Now and then lie about the tag size so the region ends off a frame boundary.
         if ($urandom_range(0, 4) == 0)
            region = 28'($urandom_range(0, 32'(region) + 20));
         flags = rand_byte();
         flags[6] = has_ext;
         put_tag_header(flags, region);
         if (has_ext) begin
            put_syncsafe(28'(ext_bytes));
            if (ext_bytes > 4)
               repeat (ext_bytes - 4) put(rand_byte());
         end
         foreach (sizes[k])
            put_frame(random_id(), 28'(sizes[k]), 16'($urandom), sizes[k]);
         repeat (pad) put(8'h00);
         repeat ($urandom_range(0, 4)) put(rand_byte());
      end
      // Truncate some files so the next start of file lands mid-structure.
      keep = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, file_buf.size()))
                                         : file_buf.size();
      send_file(1'b1, keep);
   endtask

   task automatic wait_for_drain();
      while (pending_bytes.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Driver: present the queue front at the falling edge, gap after each transfer
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (bytes_taken != bytes_taken_seen) begin
            bytes_taken_seen = bytes_taken;
            send_gap = sender_busy ? int'($urandom_range(0, 12)) : 0;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_bytes[0].value;
            req_tuser  <= pending_bytes[0].sof;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random back-pressure per result, plus a long hold on request
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (results_taken != results_taken_seen) begin
         results_taken_seen = results_taken;
         recv_gap = receiver_busy ? int'($urandom_range(0, 12)) : 0;
      end
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         recv_gap = LONG_HOLD;
      end
      if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on each input transfer, check each result transfer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      stream_item_type      taken;
      id3p_pkg::result_type want;
      logic [31:0]          got_id;
      logic [27:0]          got_size;
      logic [15:0]          got_flags;
      logic [7:0]           got_data;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            taken = pending_bytes.pop_front();
            parse_byte(taken.value, taken.sof);
            bytes_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_taken++;
            got_id    = rsp_tdata[31:0];
            got_size  = rsp_tdata[59:32];
            got_flags = rsp_tdata[75:60];
            got_data  = rsp_tdata[83:76];
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result kind %0d id %h size %h flags %h data %h last %b",
                           $realtime, rsp_tuser, got_id, got_size, got_flags, got_data, rsp_tlast);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser != want.kind || got_id != want.frame_id ||
                   got_size != want.frame_size || got_flags != want.frame_flags ||
                   got_data != want.data_byte || rsp_tlast != want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected kind %0d id %h size %h flags %h data %h last %b",
                              want.kind, want.frame_id, want.frame_size, want.frame_flags,
                              want.data_byte, want.last);
                     $display("   actual   kind %0d id %h size %h flags %h data %h last %b",
                              rsp_tuser, got_id, got_size, got_flags, got_data, rsp_tlast);
                  end
               end
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      int file_count;
      file_count = 0;
      clear_parser();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // First tag arrives without a start flag: parse straight from reset.
      put_tag_header(8'h00, 28'd11);
      put_frame(32'hFFFF_FFFF, 28'd1, 16'hFFFF, 1);
      send_file(1'b0, file_buf.size());
      // Signature broken at each of its three bytes.
      put(8'h00);
      put(8'h44);
      send_file(1'b1, file_buf.size());
      put(8'h49);
      put(8'hFF);
      put(8'h33);
      send_file(1'b1, file_buf.size());
      put(8'h49);
      put(8'h44);
      put(8'h32);
      put(8'h33);
      send_file(1'b1, file_buf.size());
      // Extended header shorter than its own size field, then a zero-size frame.
      put_tag_header(8'h40, 28'd12);
      put_syncsafe(28'd2);
      put_frame(32'h4142_4344, 28'd0, 16'h0000, 0);
      put(8'hA5);
      send_file(1'b1, file_buf.size());
      // Extended header longer than the whole tag: empty region.
      put_tag_header(8'hFF, 28'd3);
      put_syncsafe(28'd6);
      put(8'h12);
      put(8'h34);
      put(8'h56);
      put(8'h78);
      send_file(1'b1, file_buf.size());
      // Largest tag and frame sizes; cut short by the next file.
      put_tag_header(8'h00, 28'hFFF_FFFF);
      put_frame(32'h0000_0000, 28'hFFF_FFFF, 16'h8001, 2);
      send_file(1'b1, file_buf.size());
      // Zero padding reads as an id-0 frame.
      put_tag_header(8'h00, 28'd10);
      repeat (10) put(8'h00);
      put(8'h7E);
      send_file(1'b1, file_buf.size());
      // Frame that runs past the end of the region is still read in full.
      put_tag_header(8'h00, 28'd10);
      put_frame(32'h5449_5432, 28'd3, 16'h00FF, 3);
      put(8'h81);
      send_file(1'b1, file_buf.size());
      wait_for_drain();

      stimulus_bytes = 0;
      while (stimulus_bytes < RANDOM_BYTES) begin
         // Keep the send queue short so idling modes track the traffic.
         while (pending_bytes.size() > 16)
            @(posedge clock);
         if (file_count % 6 == 0) begin
            sender_busy   = ($urandom_range(0, 2) != 0);
            receiver_busy = ($urandom_range(0, 2) != 0);
         end
         if (file_count == 12) begin
            // Back up the block: sender streams flat out while the receiver holds off.
            wait_for_drain();
            sender_busy = 1'b0;
            hold_requests++;
            put_tag_header(8'h00, 28'd310);
            put_frame(random_id(), 28'd300, 16'($urandom), 300);
            send_file(1'b1, file_buf.size());
         end
         if (file_count % 10 == 9)
            wait_for_drain();
         put_random_file();
         file_count++;
      end

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== id3v2_tag_frame_parser_unit.f =====
rtl/core/id3p_pkg.sv
rtl/core/id3p_step.sv
rtl/core/id3v2_tag_frame_parser_unit.sv
rtl/core/id3p_checker.sv
bench/id3v2_tag_frame_parser_unit_tb.sv
